@@ hdl/b32d_pkg.sv @@
package b32d_pkg;

   // character classes after the alphabet lookup
   typedef enum logic [1:0] {
      KIND_SKIP    = 2'd0,
      KIND_SYMBOL  = 2'd1,
      KIND_INVALID = 2'd2
   } kind_type;

   // completion status reported with the last character of a text
   typedef enum logic [1:0] {
      STATUS_BUSY     = 2'd0,
      STATUS_OK       = 2'd1,
      STATUS_BAD_CHAR = 2'd2,
      STATUS_FRAGMENT = 2'd3
   } status_type;

   localparam int unsigned SYM_BITS  = 5;
   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned CNT_BITS  = 3;
   // at most seven bits wait between items
   localparam int unsigned BUF_BITS  = BYTE_BITS - 1;
   localparam int unsigned WIDE_BITS = BUF_BITS + SYM_BITS;

   localparam logic [CNT_BITS:0]   SYM_STEP      = 4'd5;
   localparam logic [CNT_BITS-1:0] FRAG_MIN_BITS = 3'd5;

   localparam logic [7:0] CHAR_DASH     = 8'h2d;
   localparam logic [7:0] CHAR_UNDER    = 8'h5f;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z  = 8'h7a;
   localparam logic [7:0] CASE_BIT      = 8'h20;
   localparam logic [7:0] CHAR_0        = 8'h30;
   localparam logic [7:0] CHAR_9        = 8'h39;
   localparam logic [7:0] CHAR_A        = 8'h41;
   localparam logic [7:0] CHAR_H        = 8'h48;
   localparam logic [7:0] CHAR_J        = 8'h4a;
   localparam logic [7:0] CHAR_K        = 8'h4b;
   localparam logic [7:0] CHAR_M        = 8'h4d;
   localparam logic [7:0] CHAR_N        = 8'h4e;
   localparam logic [7:0] CHAR_P        = 8'h50;
   localparam logic [7:0] CHAR_T        = 8'h54;
   localparam logic [7:0] CHAR_V        = 8'h56;
   localparam logic [7:0] CHAR_Z        = 8'h5a;

   // symbol value of the first letter of each run of the alphabet
   localparam logic [7:0] VAL_A = 8'd10;
   localparam logic [7:0] VAL_J = 8'd18;
   localparam logic [7:0] VAL_M = 8'd20;
   localparam logic [7:0] VAL_P = 8'd22;
   localparam logic [7:0] VAL_V = 8'd27;

   typedef struct packed {
      kind_type            kind;
      logic [SYM_BITS-1:0] value;
      logic                final_flag;
   } sym_type;

   typedef struct packed {
      logic                 byte_ready;
      logic [BYTE_BITS-1:0] data_byte;
      logic                 text_done;
      status_type           status;
   } result_type;

   function automatic sym_type classify_char(logic [7:0] ch, logic fin);
      sym_type    s;
      logic [7:0] up;
      s.kind       = KIND_INVALID;
      s.value      = '0;
      s.final_flag = fin;
      up           = ch;
      if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         up = ch & ~CASE_BIT;
      end
      if (ch == CHAR_DASH || ch == CHAR_UNDER || ch == CHAR_SPACE) begin
         s.kind = KIND_SKIP;
      end else begin
         case (up) inside
            [CHAR_0:CHAR_9]: begin
               s.kind  = KIND_SYMBOL;
               s.value = SYM_BITS'(up - CHAR_0);
            end
            [CHAR_A:CHAR_H]: begin
               s.kind  = KIND_SYMBOL;
               s.value = SYM_BITS'(up - CHAR_A + VAL_A);
            end
            [CHAR_J:CHAR_K]: begin
               s.kind  = KIND_SYMBOL;
               s.value = SYM_BITS'(up - CHAR_J + VAL_J);
            end
            [CHAR_M:CHAR_N]: begin
               s.kind  = KIND_SYMBOL;
               s.value = SYM_BITS'(up - CHAR_M + VAL_M);
            end
            [CHAR_P:CHAR_T]: begin
               s.kind  = KIND_SYMBOL;
               s.value = SYM_BITS'(up - CHAR_P + VAL_P);
            end
            [CHAR_V:CHAR_Z]: begin
               s.kind  = KIND_SYMBOL;
               s.value = SYM_BITS'(up - CHAR_V + VAL_V);
            end
            default: begin
               s.kind = KIND_INVALID;
            end
         endcase
      end
      return s;
   endfunction

endpackage

@@ hdl/b32d_classify.sv @@
module b32d_classify import b32d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_character,
   input  logic       in_final,
   output logic       out_valid,
   input  logic       out_ready,
   output sym_type    out_sym
);

   logic    valid_ff;
   logic    valid_in;
   sym_type sym_ff;

   // stage holds one classified item, refills as it drains
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_sym   = sym_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sym_ff <= classify_char(in_character, in_final);
      end
   end

endmodule

@@ hdl/b32d_unpack.sv @@
module b32d_unpack import b32d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  sym_type    in_sym,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [BUF_BITS-1:0]  buf_ff;
   logic [BUF_BITS-1:0]  buf_in;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [CNT_BITS-1:0]  cnt_in;
   logic                 err_ff;
   logic                 err_in;
   result_type           result_ff;
   result_type           result_in;

   logic                 advance;
   logic                 err_now;
   logic                 shift;
   logic                 emit;
   logic [WIDE_BITS-1:0] wide;
   logic [CNT_BITS:0]    cnt_sum;
   logic [CNT_BITS-1:0]  cnt_next;
   logic [BUF_BITS-1:0]  keep_mask;
   logic [BUF_BITS-1:0]  buf_next;

   assign in_ready   = !valid_ff || out_ready;
   assign advance    = in_valid && in_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      err_now   = err_ff || (in_sym.kind == KIND_INVALID);
      shift     = (in_sym.kind == KIND_SYMBOL) && !err_ff;
      wide      = {buf_ff, in_sym.value};
      cnt_sum   = {1'b0, cnt_ff} + SYM_STEP;
      emit      = shift && cnt_sum[CNT_BITS];
      // low bits of the sum are the count left over, with or without a byte out
      cnt_next  = shift ? cnt_sum[CNT_BITS-1:0] : cnt_ff;
      keep_mask = (BUF_BITS'(1) << cnt_sum[CNT_BITS-1:0]) - BUF_BITS'(1);
      if (!shift) begin
         buf_next = buf_ff;
      end else if (emit) begin
         buf_next = wide[BUF_BITS-1:0] & keep_mask;
      end else begin
         buf_next = wide[BUF_BITS-1:0];
      end

      result_in.byte_ready = emit;
      result_in.data_byte  = emit ? BYTE_BITS'(wide >> cnt_sum[CNT_BITS-1:0]) : '0;
      result_in.text_done  = in_sym.final_flag;
      if (!in_sym.final_flag) begin
         result_in.status = STATUS_BUSY;
      end else if (err_now) begin
         result_in.status = STATUS_BAD_CHAR;
      end else if (cnt_next >= FRAG_MIN_BITS) begin
         result_in.status = STATUS_FRAGMENT;
      end else begin
         result_in.status = STATUS_OK;
      end

      // last character clears the text state
      if (!advance) begin
         buf_in = buf_ff;
         cnt_in = cnt_ff;
         err_in = err_ff;
      end else if (in_sym.final_flag) begin
         buf_in = '0;
         cnt_in = '0;
         err_in = 1'b0;
      end else begin
         buf_in = buf_next;
         cnt_in = cnt_next;
         err_in = err_now;
      end

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         buf_ff   <= '0;
         cnt_ff   <= '0;
         err_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         buf_ff   <= buf_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

endmodule

@@ hdl/base32_serial_decoder.sv @@
// an accepted item is registered in the classify stage and then in the unpack stage before its result is valid
// throughput: one item per cycle, set by the classify stage and the unpack
//   stage each taking an item per cycle while the result side keeps taking
// back-pressure stalls both stages, which can hold two items between them
// reset (synchronous, active high) empties both stages and clears the bit
//   buffer, bit count and error flag
module base32_serial_decoder import b32d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_character,
   input  logic       req_final_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_byte_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_text_done,
   output logic [1:0] rsp_status
);

   // stage boundary between lookup and unpack
   logic       sym_valid;
   logic       sym_ready;
   sym_type    sym;
   result_type result;

   // stage 1: skip / symbol / invalid lookup with lower-case folding
   b32d_classify u_classify (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_character (req_character),
      .in_final     (req_final_char),
      .out_valid    (sym_valid),
      .out_ready    (sym_ready),
      .out_sym      (sym)
   );

   // stage 2: five-bit shift into the bit buffer, byte out at eight bits,
   // error tracking and end-of-text status
   b32d_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sym_valid),
      .in_ready   (sym_ready),
      .in_sym     (sym),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   // result item fields
   assign rsp_byte_ready = result.byte_ready;
   assign rsp_data_byte  = result.data_byte;
   assign rsp_text_done  = result.text_done;
   assign rsp_status     = result.status;

endmodule

@@ hdl/b32d_checker.sv @@
module b32d_checker import b32d_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_character,
   input logic       req_final_char,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_byte_ready,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_text_done,
   input logic [1:0] rsp_status
);

   // a status is reported exactly on the last item of a text
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_done == (rsp_status != STATUS_BUSY)))
      else $error("status does not match text_done");

   // no byte means a zero data field
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_ready) |-> (rsp_data_byte == 8'd0))
      else $error("data_byte nonzero without byte_ready");

   // nothing comes out in the cycle after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_byte_ready)
         && $stable(rsp_data_byte) && $stable(rsp_text_done) && $stable(rsp_status)))
      else $error("stalled result changed");

   // a waiting request holds its payload
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_character)
         && $stable(req_final_char)))
      else $error("request changed while waiting");

endmodule

bind base32_serial_decoder b32d_checker u_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

// symbol alphabet, digit value i sits in byte i counted from the left
localparam logic [8*32-1:0] B32_DIGITS = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

class text_decode_scoreboard;

   logic [11:0] held_bits;
   logic [2:0]  held_count;
   bit          bad_char_seen;
   b32d_pkg::result_type pending_results[$];
   int unsigned mismatches;

   function new();
      held_bits     = '0;
      held_count    = '0;
      bad_char_seen = 1'b0;
      mismatches    = 0;
   endfunction

   function bit is_skipped(logic [7:0] ch);
      return ch == "-" || ch == "_" || ch == " ";
   endfunction

   function bit lookup_symbol(input logic [7:0] ch, output logic [4:0] val);
      logic [7:0] up;
      val = '0;
      if (ch >= 8'd128) begin
         return 1'b0;
      end
      up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
      for (int i = 0; i < 32; i++) begin
         if (B32_DIGITS[8*(31-i) +: 8] == up) begin
            val = 5'(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // works out the result for one accepted character and queues it
   function void note_char(logic [7:0] ch, logic last_flag);
      b32d_pkg::result_type r;
      logic [4:0] val;
      logic [3:0] total;
      r = '0;
      if (!is_skipped(ch)) begin
         if (!lookup_symbol(ch, val)) begin
            bad_char_seen = 1'b1;
         end else if (!bad_char_seen) begin
            held_bits = {held_bits[6:0], val};
            total     = held_count + 4'd5;
            if (total >= 4'd8) begin
               r.byte_ready = 1'b1;
               r.data_byte  = 8'(held_bits >> (total - 4'd8));
               held_count   = 3'(total - 4'd8);
               held_bits    = held_bits & ((12'h1 << held_count) - 12'h1);
            end else begin
               held_count = total[2:0];
            end
         end
      end
      if (last_flag) begin
         r.text_done = 1'b1;
         if (bad_char_seen) begin
            r.status = b32d_pkg::STATUS_BAD_CHAR;
         end else if (held_count >= 3'd5) begin
            r.status = b32d_pkg::STATUS_FRAGMENT;
         end else begin
            r.status = b32d_pkg::STATUS_OK;
         end
         held_bits     = '0;
         held_count    = '0;
         bad_char_seen = 1'b0;
      end
      pending_results.insert(pending_results.size(), r);
   endfunction

   function void check_result(logic byte_ready, logic [7:0] data_byte, logic text_done,
                              logic [1:0] status);
      b32d_pkg::result_type want;
      if (pending_results.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected item, got ready=%b data=%h done=%b status=%0d",
                  $time, byte_ready, data_byte, text_done, status);
         return;
      end
      want = pending_results.pop_front();
      if (byte_ready !== want.byte_ready || data_byte !== want.data_byte ||
          text_done !== want.text_done || status !== want.status) begin
         mismatches++;
         $display("%0t: exp rdy=%b dat=%h done=%b st=%0d, got rdy=%b dat=%h done=%b st=%0d",
                  $time, want.byte_ready, want.data_byte, want.text_done, want.status,
                  byte_ready, data_byte, text_done, status);
      end
   endfunction

endclass

module tb_top;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEMS_PER_PHASE = 285;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_character;
   logic       req_final_char;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_byte_ready;
   logic [7:0] rsp_data_byte;
   logic       rsp_text_done;
   logic [1:0] rsp_status;

   text_decode_scoreboard sb;

   // percentages of cycles in which each side holds off
   int sender_idle_pct;
   int recv_stall_pct;
   int chars_sent;
   int idle_cycles;

   base32_serial_decoder u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_character  (req_character),
      .req_final_char (req_final_char),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte_ready (rsp_byte_ready),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_text_done  (rsp_text_done),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: ready changes only at the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: both channels sampled at the rising edge, plus the watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            sb.note_char(req_character, req_final_char);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_byte_ready, rsp_data_byte, rsp_text_done, rsp_status);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            // nothing moved for far too long, the block is hung
            $display("%0t: watchdog expired with %0d items outstanding",
                     $time, sb.pending_results.size());
            $display("Verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // drives one character; called and returns at a falling edge
   task automatic send_char(input logic [7:0] ch, input logic last_flag);
      // random gaps before the item, valid low meanwhile
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_character  <= ch;
      req_final_char <= last_flag;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_string(input string txt);
      for (int i = 0; i < txt.len(); i++) begin
         send_char(txt[i], i == txt.len() - 1);
      end
   endtask

   // sender pauses until every queued result has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // alphabet symbol in random case, now and then a skipped separator
   function automatic logic [7:0] clean_char();
      logic [7:0] ch;
      if ($urandom_range(99) < 12) begin
         case ($urandom_range(2))
            0: return "-";
            1: return "_";
            default: return " ";
         endcase
      end
      ch = B32_DIGITS[8*(31 - $urandom_range(31)) +: 8];
      if (ch >= "A" && $urandom_range(1)) begin
         ch = ch + 8'd32;
      end
      return ch;
   endfunction

   function automatic logic [7:0] bad_char();
      logic [7:0] ch;
      logic [4:0] val;
      logic [8*8-1:0] lookalikes;
      lookalikes = "IiLlOoUu";
      case ($urandom_range(2))
         0: return lookalikes[8*$urandom_range(7) +: 8];
         1: return 8'($urandom_range(255, 128));
         default: begin
            // any other ascii byte outside the alphabet and the separators
            do begin
               ch = 8'($urandom_range(127));
            end while (sb.is_skipped(ch) || sb.lookup_symbol(ch, val));
            return ch;
         end
      endcase
   endfunction

   // one text: clean, clean with one bad character, or raw noise
   task automatic send_random_text();
      int len;
      int bad_pos;
      int kind_pick;
      logic [7:0] ch;
      kind_pick = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 14) : $urandom_range(13, 1);
      bad_pos = $urandom_range(len - 1);
      for (int i = 0; i < len; i++) begin
         if (kind_pick < 80) begin
            ch = clean_char();
         end else if (kind_pick < 92) begin
            ch = (i == bad_pos) ? bad_char() : clean_char();
         end else begin
            ch = 8'($urandom_range(255));
         end
         send_char(ch, i == len - 1);
      end
   endtask

   initial begin
      sb              = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_character   = '0;
      req_final_char  = 1'b0;
      rsp_ready       = 1'b0;
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      chars_sent      = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
         endcase

         if (phase == 0) begin
            // all-ones symbols, five full bytes, clean finish
            send_string("ZZZZZZZZ");
            // an all-zero byte, two bits left over is still ok
            send_string("00");
            // separators only, no bytes at all
            send_string("-_ ");
            // lower case, then a lookalike letter poisons the text
            send_string("zyI1");
            // lone high byte that is also the last character
            send_char(8'hff, 1'b1);
            // seven bits left over gives a fragment status
            send_string("abc");
            // non-ascii in the middle, a lookalike as last character
            send_char("9", 1'b0);
            send_char(8'h80, 1'b0);
            send_char("u", 1'b1);
         end

         chars_sent = 0;
         while (chars_sent < ITEMS_PER_PHASE) begin
            send_random_text();
            // in phase 1, hold off mid phase until everything has drained
            if (phase == 1 && chars_sent >= ITEMS_PER_PHASE / 2 &&
                chars_sent < ITEMS_PER_PHASE / 2 + 14) begin
               drain();
            end
         end
         drain();
      end

      // a little extra time for any stray item from the two-stage pipe
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ base32_serial_decoder.f @@
hdl/b32d_pkg.sv
hdl/b32d_classify.sv
hdl/b32d_unpack.sv
hdl/base32_serial_decoder.sv
hdl/b32d_checker.sv
sim/tb_top.sv
